@@ rtl/core/max_pool_2x2_stream_macros.svh @@
// Assertion macros for the max pooling RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef MAX_POOL_2X2_STREAM_MACROS_SVH
`define MAX_POOL_2X2_STREAM_MACROS_SVH

// Assert that prop holds at every rising edge outside reset.
`define MP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that cond at one edge implies conseq at the next edge.
`define MP_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

@@ rtl/core/mp2x2_pkg.sv @@
// Package for the 2x2 max pooling block: widths, constants, compare function.
// Depends on nothing.
package mp2x2_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int WIDTH_BITS    = 11;
   localparam int HEIGHT_BITS   = 16;
   localparam int SAMPLE_BITS   = 32;
   localparam logic [31:0] NEG_INF = 32'hFF80_0000;
   localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 11'd8;
   localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 16'd8;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   // Role of an item, decided by the front part.
   typedef enum logic [3:0] {
      OP_DROP     = 4'b0001,
      OP_UP_LEFT  = 4'b0010,
      OP_UP_RIGHT = 4'b0100,
      OP_LOW      = 4'b1000
   } op_type;

   function automatic logic is_nan(input logic [31:0] x);
      is_nan = (x[30:0] > 31'h7F80_0000);
   endfunction

   // True when a < b in IEEE ordering; false when either is NaN.
   function automatic logic ieee_less(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      if (is_nan(a) || is_nan(b)) begin
         ieee_less = 1'b0;
      end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
         ieee_less = 1'b0;
      end else begin
         ieee_less = (ka < kb);
      end
   endfunction

   function automatic logic [31:0] keep_max(input logic [31:0] run, input logic [31:0] x);
      keep_max = ieee_less(run, x) ? x : run;
   endfunction

endpackage

@@ rtl/core/mp2x2_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mp2x2_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mp2x2_front.sv @@
// Front part: counts columns and rows, classifies each item and hands it on.
// Depends on mp2x2_pkg.
module mp2x2_front
   import mp2x2_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int PAIR_W = $clog2(MAX_WIDTH / 2)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [WIDTH_BITS-1:0]  cfg_width,
   input  logic [HEIGHT_BITS-1:0] cfg_height,
   input  logic                   restart,
   input  logic                   in_valid,
   input  logic                   in_take,
   output op_type                 op,
   output logic [PAIR_W-1:0]      pair,
   output logic                   col_odd,
   output logic                   last
);

   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0]          col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [CW-1:0]          eff_w, used_w;
   logic [HEIGHT_BITS-1:0] eff_h, used_h;
   logic                   active;

   always_comb begin
      if (cfg_width < 11'd2) begin
         eff_w = CW'(2);
      end else if ({21'd0, cfg_width} > MAX_WIDTH) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(cfg_width);
      end
      eff_h   = (cfg_height < 16'd2) ? 16'd2 : cfg_height;
      used_w  = {eff_w[CW-1:1], 1'b0};
      used_h  = {eff_h[HEIGHT_BITS-1:1], 1'b0};
      active  = (col_ff < used_w) && (row_ff < used_h);
      pair    = col_ff[PAIR_W:1];
      col_odd = col_ff[0];
      last    = (row_ff == used_h - 16'd1) && (col_ff == used_w - CW'(1));
      if (!active) begin
         op = OP_DROP;
      end else if (row_ff[0]) begin
         op = OP_LOW;
      end else if (col_ff[0]) begin
         op = OP_UP_RIGHT;
      end else begin
         op = OP_UP_LEFT;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (in_valid && in_take) begin
         if (col_ff + CW'(1) >= eff_w) begin
            col_in = '0;
            row_in = (row_ff + 16'd1 >= eff_h) ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/core/mp2x2_back.sv @@
// Back part: line store of upper-row pair maxima, lower-row compare, output register.
// Depends on mp2x2_pkg, mp2x2_ram, mp2x2_side and the assertion macro header.
`include "max_pool_2x2_stream_macros.svh"
module mp2x2_back
   import mp2x2_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int PAIR_W = $clog2(MAX_WIDTH / 2)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  op_type            in_op,
   input  logic [PAIR_W-1:0] in_pair,
   input  logic              in_odd,
   input  logic              in_last,
   input  logic [31:0]       in_sample,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [31:0]       out_bits,
   output logic              out_end
);

   // Stage 1 holds the item while the line store read completes.
   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff;
   logic [PAIR_W-1:0] s1_pair_ff;
   logic              s1_last_ff;
   logic [31:0]       s1_x_ff;
   logic              s1_right;
   logic [31:0]       left_ff, left_in;
   logic [31:0]       ram_rd;
   logic              ram_we;
   logic [31:0]       ram_wd;
   logic              bypass;
   logic [31:0]       upper;
   logic              adv;
   logic              fwd_ff;
   logic [31:0]       fwd_data_ff;
   logic              in_push;
   // Two-entry output queue keeps the rate when the consumer stalls.
   logic [1:0]        cnt_ff, cnt_in;
   logic [32:0]       q_ff [2];
   logic              push, pop;
   logic              push_head;
   logic [31:0]       res;

   assign pop      = out_valid && !out_stall;
   // Only a lower-right item adds a result, so only such an item is held back, and only
   // when the queue might have no room for it on the next cycle.
   assign in_push  = (in_op == OP_LOW) && in_odd;
   assign in_stall = in_push && ((cnt_ff == 2'd2) || (cnt_ff == 2'd1 && push));
   assign adv      = in_valid && !in_stall;

   // Stage 1 sees the store as of the previous write; forward that write on a hit.
   assign bypass = ram_we && (s1_pair_ff == in_pair);

   mp2x2_ram #(.DATA_W(32), .DEPTH(MAX_WIDTH / 2)) u_line (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(s1_pair_ff),
      .wr_data(ram_wd),
      .rd_en  (adv),
      .rd_addr(in_pair),
      .rd_data(ram_rd)
   );

   // Lower-row parity travels as a separate bit.
   mp2x2_side u_side (
      .clock  (clock),
      .adv    (adv),
      .col_odd(in_odd),
      .right  (s1_right)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_ff      <= bypass;
         fwd_data_ff <= ram_wd;
      end
   end

   assign upper = fwd_ff ? fwd_data_ff : ram_rd;

   always_comb begin
      ram_we = 1'b0;
      ram_wd = keep_max(NEG_INF, s1_x_ff);
      left_in = left_ff;
      res = keep_max(left_ff, s1_x_ff);
      push = 1'b0;
      case (s1_op_ff)
         OP_UP_LEFT: begin
            ram_we = s1_valid_ff;
         end
         OP_UP_RIGHT: begin
            ram_we = s1_valid_ff;
            ram_wd = keep_max(upper, s1_x_ff);
         end
         OP_LOW: begin
            if (s1_valid_ff && !s1_right) begin
               left_in = keep_max(upper, s1_x_ff);
            end
            push = s1_valid_ff && s1_right;
         end
         OP_DROP: begin
         end
         default: begin
         end
      endcase
   end

   assign s1_valid_in = adv;
   assign push_head   = push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
      end
      if (adv) begin
         s1_op_ff   <= in_op;
         s1_pair_ff <= in_pair;
         s1_last_ff <= in_last;
         s1_x_ff    <= in_sample;
      end
      left_ff <= left_in;
      if (push_head) begin
         q_ff[0] <= {s1_last_ff, res};
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (push && !push_head) begin
         q_ff[1] <= {s1_last_ff, res};
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_bits  = q_ff[0][31:0];
   assign out_end   = q_ff[0][32];

   `MP_ASSERT(a_cnt_range, clock, reset, cnt_ff != 2'd3, "output queue count out of range")
   `MP_ASSERT(a_no_overflow, clock, reset, !(push && cnt_ff == 2'd2 && !pop), "output queue overflow")
   `MP_ASSERT_NEXT(a_push_shows, clock, reset, push, out_valid, "pushed result not shown")

endmodule

@@ rtl/core/mp2x2_side.sv @@
// Lower-row parity tracker for the back part.
// Depends on nothing.
module mp2x2_side (
   input  logic clock,
   input  logic adv,
   input  logic col_odd,
   output logic right
);
   logic right_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         right_ff <= col_odd;
      end
   end
   assign right = right_ff;
endmodule

@@ rtl/core/max_pool_2x2_stream.sv @@
// 2x2 max pooling, stride 2, over IEEE single samples in raster order. One sample is
// accepted per clock while req_stall is low. A result passes the compare stage and then
// the two-entry output queue after the lower-right sample of its window is accepted.
// Only a lower-right sample is ever stalled, when the queue is full or may fill.
// The line store holds MAX_WIDTH/2 upper-row pair maxima. Odd trailing rows and columns
// are dropped. Writing plane_width (0x0) or plane_height (0x4) restarts the plane.
module max_pool_2x2_stream
   import mp2x2_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pooled_bits,
   output logic        rsp_plane_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PAIR_W = $clog2(MAX_WIDTH / 2);

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic                   wr;
   op_type                 op;
   logic [PAIR_W-1:0]      pair;
   logic                   col_odd;
   logic                   last;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? {16'd0, height_ff} : {21'd0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == REG_WIDTH) begin
            width_ff <= csr_pwdata[WIDTH_BITS-1:0];
         end else begin
            height_ff <= csr_pwdata[HEIGHT_BITS-1:0];
         end
      end
   end

   mp2x2_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg_width (width_ff),
      .cfg_height(height_ff),
      .restart   (wr && csr_paddr[1:0] == 2'd0),
      .in_valid  (req_valid),
      .in_take   (!req_stall),
      .op        (op),
      .pair      (pair),
      .col_odd   (col_odd),
      .last      (last)
   );

   mp2x2_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_op    (op),
      .in_pair  (pair),
      .in_odd   (col_odd),
      .in_last  (last),
      .in_sample(req_sample_bits),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_bits (rsp_pooled_bits),
      .out_end  (rsp_plane_end)
   );

endmodule
